/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hw/rtl/f32em_pkg.sv */
package f32em_pkg;

   localparam int LANES_DEF  = 4;
   localparam int PIPE_DEPTH = 13;
   localparam int FP_W       = 32;

   localparam logic [31:0] X_FLOOR    = 32'hC18AA123;
   localparam logic [31:0] MAGIC_BIAS = 32'h49400000;
   localparam logic [31:0] NEG_MAGIC  = 32'hC9400000;
   localparam logic [31:0] LOG2E      = 32'h3FB8AA3B;
   localparam logic [31:0] NEG_LN2_HI = 32'hBF317200;
   localparam logic [31:0] NEG_LN2_LO = 32'hB5BFBE8E;
   localparam logic [31:0] POLY_C3    = 32'h3E2AAB0E;
   localparam logic [31:0] POLY_C2    = 32'h3F0000F6;
   localparam logic [31:0] NEG_ONE    = 32'hBF800000;
   localparam logic [31:0] QNAN_BIT   = 32'h00400000;
   localparam logic [31:0] DEF_NAN    = 32'hFFC00000;
   localparam logic [30:0] INF_MAG    = 31'h7F800000;
   localparam int          EXP_SHIFT  = 19;

   // 2^(k/16) as float32 bits, minus k<<19.
   function automatic logic [31:0] f_frac_rom(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0:    r = 32'h3F800000;
         4'd1:    r = 32'h3F7DAAC3;
         4'd2:    r = 32'h3F7B95C2;
         4'd3:    r = 32'h3F79C3D3;
         4'd4:    r = 32'h3F7837F0;
         4'd5:    r = 32'h3F76F532;
         4'd6:    r = 32'h3F75FED7;
         4'd7:    r = 32'h3F75583F;
         4'd8:    r = 32'h3F7504F3;
         4'd9:    r = 32'h3F7508A4;
         4'd10:   r = 32'h3F75672A;
         4'd11:   r = 32'h3F76248C;
         4'd12:   r = 32'h3F7744FD;
         4'd13:   r = 32'h3F78CCDF;
         4'd14:   r = 32'h3F7AC0C7;
         default: r = 32'h3F7D257D;
      endcase
      return r;
   endfunction

   function automatic logic f_isnan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic [5:0] f_lzc49(input logic [48:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd49;
      found = 1'b0;
      for (int i = 48; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(48 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Rounds a normalized significand (leading one at bit 48) to nearest-even.
   function automatic logic [31:0] f_round(input logic sgn,
                                           input logic signed [11:0] be_i,
                                           input logic [48:0] sig_i);
      logic signed [11:0] be;
      logic [48:0]        sig;
      logic               st;
      logic [5:0]         sh;
      logic [23:0]        m;
      logic               g;
      logic               s;
      logic [24:0]        mr;
      logic [31:0]        r;
      be  = be_i;
      sig = sig_i;
      st  = 1'b0;
      sh  = 6'd0;
      if (be < 12'sd1) begin
         if (be < -12'sd47) begin
            st  = |sig;
            sig = '0;
         end else begin
            sh  = 6'(12'sd1 - be);
            st  = |(sig & ~({49{1'b1}} << sh));
            sig = sig >> sh;
         end
         sig[0] = sig[0] | st;
         be     = 12'sd1;
      end
      m  = sig[48:25];
      g  = sig[24];
      s  = |sig[23:0];
      mr = {1'b0, m} + 25'(g & (s | m[0]));
      if (mr[24]) begin
         mr = mr >> 1;
         be = be + 12'sd1;
      end
      if (be >= 12'sd255) begin
         r = {sgn, 8'hFF, 23'd0};
      end else begin
         r = {sgn, (mr[23] ? be[7:0] : 8'd0), mr[22:0]};
      end
      return r;
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      logic               sg;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        pr;
      logic [48:0]        sig;
      logic [5:0]         lz;
      logic signed [11:0] be;
      logic               ai;
      logic               bi;
      logic               az;
      logic               bz;
      logic [31:0]        r;
      sg  = a[31] ^ b[31];
      ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma  = {a[30:23] != 8'd0, a[22:0]};
      mb  = {b[30:23] != 8'd0, b[22:0]};
      ai  = a[30:0] == INF_MAG;
      bi  = b[30:0] == INF_MAG;
      az  = a[30:0] == 31'd0;
      bz  = b[30:0] == 31'd0;
      pr  = ma * mb;
      sig = {pr, 1'b0};
      lz  = f_lzc49(sig);
      sig = sig << lz;
      be  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126
            - $signed({6'd0, lz});
      if (f_isnan(a)) begin
         r = a | QNAN_BIT;
      end else if (f_isnan(b)) begin
         r = b | QNAN_BIT;
      end else if ((ai && bz) || (bi && az)) begin
         r = DEF_NAN;
      end else if (ai || bi) begin
         r = {sg, INF_MAG};
      end else if (az || bz) begin
         r = {sg, 31'd0};
      end else begin
         r = f_round(sg, be, sig);
      end
      return r;
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]        x;
      logic [31:0]        y;
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         d;
      logic [48:0]        xs;
      logic [48:0]        ys;
      logic [48:0]        sm;
      logic               st;
      logic [5:0]         lz;
      logic signed [11:0] be;
      logic               ai;
      logic               bi;
      logic [31:0]        r;
      ai = a[30:0] == INF_MAG;
      bi = b[30:0] == INF_MAG;
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d  = ex - ey;
      xs = {1'b0, x[30:23] != 8'd0, x[22:0], 24'd0};
      ys = {1'b0, y[30:23] != 8'd0, y[22:0], 24'd0};
      if (d > 8'd48) begin
         st = |ys;
         ys = {48'd0, st};
      end else begin
         st    = |(ys & ~({49{1'b1}} << d[5:0]));
         ys    = ys >> d[5:0];
         ys[0] = ys[0] | st;
      end
      sm = (x[31] ^ y[31]) ? (xs - ys) : (xs + ys);
      lz = f_lzc49(sm);
      be = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
      if (f_isnan(a)) begin
         r = a | QNAN_BIT;
      end else if (f_isnan(b)) begin
         r = b | QNAN_BIT;
      end else if (ai && bi && (a[31] != b[31])) begin
         r = DEF_NAN;
      end else if (ai) begin
         r = a;
      end else if (bi) begin
         r = b;
      end else if (sm == 49'd0) begin
         r = {a[31] & b[31], 31'd0};
      end else begin
         r = f_round(x[31], be, sm << lz);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/f32em_lane.sv */
// One expm1 lane: thirteen registered stages, one rounded float operation
// (or up to three independent ones) per stage. All stages advance together on adv.
module f32em_lane (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] x,
   output logic [31:0] y
);

   localparam int BYP_N = f32em_pkg::PIPE_DEPTH - 1;

   logic [31:0] xc;
   logic [31:0] sb_in;
   logic [31:0] m1_ff, n_ff, nm_ff, s_ff, a_ff, t1_ff, b_ff, t_ff, c_ff, p1_ff;
   logic [31:0] p_ff, ts_ff, sm1_ff, q_ff, r_ff, y_ff;
   logic [31:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic [31:0] nm4_ff, nm5_ff;
   logic [31:0] s4_ff, s5_ff, s6_ff, s7_ff, s8_ff, s9_ff;
   logic [31:0] t8_ff, t9_ff;
   logic [31:0] ts11_ff, sm11_ff, sm12_ff;
   logic [31:0] t16_ff;
   logic        nan_ff [BYP_N];
   logic [31:0] bv_ff  [BYP_N];

   // Inputs below the cutoff, minus infinity included, saturate to -1.
   assign xc = (x[31] && (x[30:0] > f32em_pkg::X_FLOOR[30:0])) ?
               f32em_pkg::X_FLOOR : x;

   // Scale bits: table entry plus the biased n shifted into the exponent.
   assign sb_in = f32em_pkg::f_frac_rom(n_ff[3:0]) + (n_ff << f32em_pkg::EXP_SHIFT);

   always_ff @(posedge clock) begin
      if (adv) begin
         nan_ff[0] <= f32em_pkg::f_isnan(x);
         bv_ff[0]  <= x | f32em_pkg::QNAN_BIT;
         for (int i = 1; i < BYP_N; i++) begin
            nan_ff[i] <= nan_ff[i-1];
            bv_ff[i]  <= bv_ff[i-1];
         end
         m1_ff   <= f32em_pkg::f_mul(xc, f32em_pkg::LOG2E);
         x1_ff   <= xc;
         n_ff    <= f32em_pkg::f_add(m1_ff, f32em_pkg::MAGIC_BIAS);
         x2_ff   <= x1_ff;
         s_ff    <= sb_in;
         nm_ff   <= f32em_pkg::f_add(n_ff, f32em_pkg::NEG_MAGIC);
         x3_ff   <= x2_ff;
         a_ff    <= f32em_pkg::f_mul(nm_ff, f32em_pkg::NEG_LN2_HI);
         nm4_ff  <= nm_ff;
         s4_ff   <= s_ff;
         x4_ff   <= x3_ff;
         t1_ff   <= f32em_pkg::f_add(a_ff, x4_ff);
         nm5_ff  <= nm4_ff;
         s5_ff   <= s4_ff;
         b_ff    <= f32em_pkg::f_mul(nm5_ff, f32em_pkg::NEG_LN2_LO);
         t16_ff  <= t1_ff;
         s6_ff   <= s5_ff;
         t_ff    <= f32em_pkg::f_add(b_ff, t16_ff);
         s7_ff   <= s6_ff;
         c_ff    <= f32em_pkg::f_mul(f32em_pkg::POLY_C3, t_ff);
         t8_ff   <= t_ff;
         s8_ff   <= s7_ff;
         p1_ff   <= f32em_pkg::f_add(c_ff, f32em_pkg::POLY_C2);
         t9_ff   <= t8_ff;
         s9_ff   <= s8_ff;
         p_ff    <= f32em_pkg::f_mul(p1_ff, t9_ff);
         ts_ff   <= f32em_pkg::f_mul(t9_ff, s9_ff);
         sm1_ff  <= f32em_pkg::f_add(s9_ff, f32em_pkg::NEG_ONE);
         q_ff    <= f32em_pkg::f_mul(p_ff, ts_ff);
         ts11_ff <= ts_ff;
         sm11_ff <= sm1_ff;
         r_ff    <= f32em_pkg::f_add(q_ff, ts11_ff);
         sm12_ff <= sm11_ff;
         y_ff    <= nan_ff[BYP_N-1] ? bv_ff[BYP_N-1] : f32em_pkg::f_add(r_ff, sm12_ff);
      end
   end

   assign y = y_ff;

endmodule

/* hw/rtl/f32em_ctrl.sv */
`include "assert_macros.svh"

// Valid and last tracking for the lane pipeline. The whole pipeline moves
// whenever the output slot is empty or being taken this cycle.
module f32em_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tlast,
   output logic req_tready,
   output logic rsp_tvalid,
   output logic rsp_tlast,
   input  logic rsp_tready,
   output logic adv
);

   localparam int D = f32em_pkg::PIPE_DEPTH;

   logic [D-1:0] vld_ff;
   logic [D-1:0] vld_in;
   logic [D-1:0] last_ff;

   assign adv        = !vld_ff[D-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[D-1];
   assign rsp_tlast  = last_ff[D-1];
   assign vld_in     = {vld_ff[D-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= {last_ff[D-2:0], req_tlast};
      end
   end

   `ASSERT_CLK(a_hold_on_stall, clock, reset, !adv |=> $stable(vld_ff))
   `ASSERT_CLK(a_accept_enters, clock, reset, (req_tvalid && req_tready) |=> vld_ff[0])
   `ASSERT_CLK(a_backpressure, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)

endmodule

/* hw/rtl/f32_expm1_negative_lut16_poly3.sv */
// expm1 on four (LANES) float32 values per transfer, for x in [-17.33, 0].
// Input channel req_*: one transfer carries all lanes in req_tdata, lane 0 in
// the lowest 32 bits, and req_tlast marks the final group of an array.
// Result channel rsp_*: rsp_tdata holds exp(x)-1 per lane in the same order,
// and rsp_tlast repeats the tlast of the matching input transfer.
// Each lane is a 13-stage pipeline that performs one or more separately
// rounded binary32 multiplies or adds per stage (round to nearest even,
// subnormals kept). The block takes one transfer per cycle while the
// output is not stalled; all lanes run in lock step and the last stage of
// every lane is the output register.
// NaN inputs come out quieted; inputs below the cutoff give -1.0.
// After reset the pipeline is empty and rsp_tvalid is low.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops in the same cycle; nothing is lost or duplicated.
// Results for positive inputs follow the same operation sequence and are
// outside the intended domain.
module f32_expm1_negative_lut16_poly3 #(
   parameter int LANES = f32em_pkg::LANES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // x_lane0 .. x_lane(LANES-1), 32 bits each, from the lowest bit up.
   input  logic [LANES*f32em_pkg::FP_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // y_lane0 .. y_lane(LANES-1), 32 bits each, from the lowest bit up.
   output logic [LANES*f32em_pkg::FP_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   logic adv;

   // Control: one valid/last shift line shared by every lane.
   f32em_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready),
      .adv        (adv)
   );

   // The lanes are independent; their registered results are merged side by
   // side into the output transfer.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      f32em_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .x     (req_tdata[g*f32em_pkg::FP_W +: f32em_pkg::FP_W]),
         .y     (rsp_tdata[g*f32em_pkg::FP_W +: f32em_pkg::FP_W])
      );
   end

endmodule

/* sim/tb_f32_expm1_negative_lut16_poly3.sv */
`timescale 1ns / 100ps

module tb_f32_expm1_negative_lut16_poly3;

   localparam int LANES = 4;

   // Single-precision constants used by the expm1 recipe, as bit patterns.
   localparam logic [31:0] CUTOFF_BITS  = 32'hC18AA123;  // -17.328680
   localparam logic [31:0] BIAS_BITS    = 32'h49400000;  // 1.5 * 2^19
   localparam logic [31:0] NEG_BIAS     = 32'hC9400000;
   localparam logic [31:0] LOG2E_BITS   = 32'h3FB8AA3B;
   localparam logic [31:0] LN2_HI_NEG   = 32'hBF317200;
   localparam logic [31:0] LN2_LO_NEG   = 32'hB5BFBE8E;
   localparam logic [31:0] C3_BITS      = 32'h3E2AAB0E;
   localparam logic [31:0] C2_BITS      = 32'h3F0000F6;
   localparam logic [31:0] MINUS_ONE    = 32'hBF800000;
   localparam logic [31:0] QUIET_BIT    = 32'h00400000;
   localparam logic [31:0] DEFAULT_NAN  = 32'hFFC00000;
   localparam logic [30:0] INF_MAGN     = 31'h7F800000;
   localparam int          SCALE_SHIFT  = 19;
   localparam int          LATENCY      = 13;
   localparam int          ITEM_COUNT   = 450;
   localparam int          QUIET_TAIL   = 60;

   typedef struct packed {
      logic [LANES*32-1:0] lanes;
      logic                last;
   } group_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // x_lane0 .. x_lane3, 32 bits each, from the lowest bit up.
   logic [LANES*32-1:0]   req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // y_lane0 .. y_lane3, 32 bits each, from the lowest bit up.
   logic [LANES*32-1:0]   rsp_tdata;
   logic                  rsp_tlast;

   group_type pending_groups[$];
   group_type expected_groups[$];
   int     groups_sent;
   int     groups_checked;
   int     mismatches;
   int     send_gap;
   int     recv_gap;
   int     hold_cycles;
   bit     hold_done;

   f32_expm1_negative_lut16_poly3 #(.LANES(LANES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------
   // Bit-exact binary32 arithmetic, round to nearest even, subnormals kept.
   // ---------------------------------------------------------------------

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // Rounds the exact value mag * 2^lsb_exp (mag > 0) to a float32.
   function automatic logic [31:0] round_to_f32(input logic sgn, input int lsb_exp,
                                                input logic [127:0] mag);
      int          top;
      int          lead_exp;
      int          lsb_w;
      int          sh;
      logic [127:0] m;
      logic        guard;
      logic        sticky;
      top = 0;
      for (int i = 0; i < 128; i++)
         if (mag[i]) top = i;
      lead_exp = top + lsb_exp;
      lsb_w = (lead_exp - 23 < -149) ? -149 : lead_exp - 23;
      sh = lsb_w - lsb_exp;
      guard = 1'b0;
      sticky = 1'b0;
      if (sh <= 0) begin
         m = mag << (-sh);
      end else if (sh > 120) begin
         m = '0;
         sticky = |mag;
      end else begin
         m = mag >> sh;
         guard = mag[sh-1];
         sticky = |(mag & ~({128{1'b1}} << (sh - 1)));
      end
      if (guard && (sticky || m[0])) m = m + 128'd1;
      if (m[24]) begin
         m = m >> 1;
         lsb_w = lsb_w + 1;
      end
      if (lsb_w + 150 >= 255)
         return {sgn, INF_MAGN};
      if (!m[23])
         return {sgn, 8'd0, m[22:0]};
      return {sgn, 8'(lsb_w + 150), m[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sgn;
      logic [23:0] ma;
      logic [23:0] mb;
      int          la;
      int          lb;
      sgn = a[31] ^ b[31];
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if ((a[30:0] == INF_MAGN && b[30:0] == 31'd0) ||
          (b[30:0] == INF_MAGN && a[30:0] == 31'd0)) return DEFAULT_NAN;
      if (a[30:0] == INF_MAGN || b[30:0] == INF_MAGN) return {sgn, INF_MAGN};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      la = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
      lb = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
      return round_to_f32(sgn, la + lb, 128'(ma) * 128'(mb));
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  big;
      logic [31:0]  tiny;
      logic [127:0] mb;
      logic [127:0] mt;
      logic [127:0] sum;
      int           lbig;
      int           ltiny;
      int           d;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (a[30:0] == INF_MAGN && b[30:0] == INF_MAGN && a[31] != b[31])
         return DEFAULT_NAN;
      if (a[30:0] == INF_MAGN) return a;
      if (b[30:0] == INF_MAGN) return b;
      if (a[30:0] >= b[30:0]) begin
         big = a;
         tiny = b;
      end else begin
         big = b;
         tiny = a;
      end
      mb = 128'({big[30:23] != 8'd0, big[22:0]});
      mt = 128'({tiny[30:23] != 8'd0, tiny[22:0]});
      lbig = ((big[30:23] == 8'd0) ? 1 : int'(big[30:23])) - 150;
      ltiny = ((tiny[30:23] == 8'd0) ? 1 : int'(tiny[30:23])) - 150;
      d = lbig - ltiny;
      // Far below the larger operand, the smaller one only acts as a sticky bit.
      if (d > 50) begin
         mb = mb << 50;
         mt = (mt != 0) ? 128'd1 : 128'd0;
         ltiny = lbig - 50;
      end else begin
         mb = mb << d;
      end
      sum = (a[31] ^ b[31]) ? mb - mt : mb + mt;
      if (sum == 0) return {a[31] & b[31], 31'd0};
      return round_to_f32(big[31], ltiny, sum);
   endfunction

   // 2^(k/16) as float32 bits with k<<19 taken off, so adding the biased
   // integer bits shifted up lands the scale's exponent in place.
   function automatic logic [31:0] exp2_frac(input logic [3:0] k);
      logic [31:0] tbl[16];
      tbl = '{32'h3F800000, 32'h3F7DAAC3, 32'h3F7B95C2, 32'h3F79C3D3,
              32'h3F7837F0, 32'h3F76F532, 32'h3F75FED7, 32'h3F75583F,
              32'h3F7504F3, 32'h3F7508A4, 32'h3F75672A, 32'h3F76248C,
              32'h3F7744FD, 32'h3F78CCDF, 32'h3F7AC0C7, 32'h3F7D257D};
      return tbl[k];
   endfunction

   function automatic logic [31:0] expm1_lane(input logic [31:0] xin);
      logic [31:0] x;
      logic [31:0] n;
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] p;
      logic [31:0] ts;
      logic [31:0] sm1;
      if (is_nan(xin)) return xin | QUIET_BIT;
      x = xin;
      // Clamp when x is below the cutoff, minus infinity included.
      if (x[31] && x[30:0] > CUTOFF_BITS[30:0]) x = CUTOFF_BITS;
      n   = fp_add(fp_mul(x, LOG2E_BITS), BIAS_BITS);
      s   = exp2_frac(n[3:0]) + (n << SCALE_SHIFT);
      n   = fp_add(n, NEG_BIAS);
      t   = fp_add(fp_mul(n, LN2_HI_NEG), x);
      t   = fp_add(fp_mul(n, LN2_LO_NEG), t);
      p   = fp_add(fp_mul(C3_BITS, t), C2_BITS);
      p   = fp_mul(p, t);
      ts  = fp_mul(t, s);
      sm1 = fp_add(s, MINUS_ONE);
      p   = fp_add(fp_mul(p, ts), ts);
      return fp_add(p, sm1);
   endfunction

   function automatic group_type expm1_group(input group_type g);
      group_type r;
      for (int i = 0; i < LANES; i++)
         r.lanes[32*i +: 32] = expm1_lane(g.lanes[32*i +: 32]);
      r.last = g.last;
      return r;
   endfunction

   // Mostly in-range negatives; some fully random patterns for coverage of
   // every bit, NaNs and the positive side.
   function automatic logic [31:0] random_x();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return {1'b1, 8'($urandom_range(90, 131)), 23'($urandom)};
      if (pick < 9)
         return $urandom;
      return {1'b1, 8'($urandom_range(0, 5)), 23'($urandom)};
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and stimulus.
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      logic [31:0] directed[$];
      group_type   g;
      reset = 1'b1;
      // Zeros, the cutoff and below it, infinities, a quiet NaN, signaling NaNs
      // of both signs, subnormals, ordinary negatives and a few positives.
      directed = '{32'h00000000, 32'h80000000, CUTOFF_BITS, 32'hC18AA124,
                   32'hC2000000, 32'hFF800000, 32'h7F800000, 32'h7FC00000,
                   32'h7F800001, 32'hFFA12345, 32'h80000001, 32'h807FFFFF,
                   32'h00000001, 32'h80800000, MINUS_ONE, 32'hBF000000,
                   32'h3F800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h42B00000,
                   32'hC1800000, 32'hB3800000, 32'h3E800000, 32'hC0A00000};
      for (int i = 0; i < directed.size(); i += LANES) begin
         for (int k = 0; k < LANES; k++)
            g.lanes[32*k +: 32] = directed[(i + k) % directed.size()];
         g.last = 1'((i / LANES) % 2);
         pending_groups.push_back(g);
      end
      for (int i = 0; i < ITEM_COUNT; i++) begin
         for (int k = 0; k < LANES; k++)
            g.lanes[32*k +: 32] = random_x();
         g.last = ($urandom_range(0, 7) == 0);
         pending_groups.push_back(g);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every group has gone in and every result has come back.
      while (pending_groups.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_groups.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);

      $display("Sent %0d and checked %0d four-lane groups: special values, clamping,",
               groups_sent, groups_checked);
      $display("subnormals, in-range negatives and random patterns, under random stalls.");
      if (mismatches == 0 && expected_groups.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Timeout with %0d results outstanding", expected_groups.size());
      $display("TEST FAILED");
      $finish;
   end

   // Sender: offers the next pending group, with random idle bursts until
   // the last part of the run.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         send_gap <= 0;
         groups_sent <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_groups.size() != 0) begin
            req_tdata <= pending_groups[0].lanes;
            req_tlast <= pending_groups[0].last;
            req_tvalid <= 1'b1;
            void'(pending_groups.pop_front());
            groups_sent <= groups_sent + 1;
            if (pending_groups.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
               send_gap <= $urandom_range(1, 18);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Every accepted input transfer queues its expected result.
   always @(posedge clock) begin
      group_type g;
      if (!reset && req_tvalid && req_tready) begin
         g.lanes = req_tdata;
         g.last = req_tlast;
         expected_groups.push_back(expm1_group(g));
      end
   end

   // Receiver: random stall bursts, one long hold-off early in the run so
   // the pipeline fills and pushes back on the sender, and none at the end.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && groups_checked >= 40) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == 80) hold_done <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (pending_groups.size() > QUIET_TAIL && $urandom_range(0, 6) == 0)
            recv_gap <= $urandom_range(1, 18);
      end
   end

   // Compares each result transfer against the oldest expectation.
   always @(posedge clock) begin
      group_type want;
      bit     bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_groups.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("Unexpected result transfer: data %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_groups.pop_front();
            bad = (rsp_tlast !== want.last);
            for (int i = 0; i < LANES; i++)
               if (rsp_tdata[32*i +: 32] !== want.lanes[32*i +: 32]) bad = 1'b1;
            if (bad) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  for (int i = 0; i < LANES; i++)
                     $display("Group %0d lane %0d: expected %h, got %h", groups_checked,
                              i, want.lanes[32*i +: 32], rsp_tdata[32*i +: 32]);
                  $display("Group %0d last: expected %b, got %b", groups_checked,
                           want.last, rsp_tlast);
               end
            end
         end
         groups_checked <= groups_checked + 1;
      end
   end

   initial begin
      mismatches = 0;
      groups_checked = 0;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/f32em_pkg.sv
hw/rtl/f32em_lane.sv
hw/rtl/f32em_ctrl.sv
hw/rtl/f32_expm1_negative_lut16_poly3.sv
sim/tb_f32_expm1_negative_lut16_poly3.sv
